@@ design/spq_pkg.sv @@
package spq_pkg;

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_DEQUEUE = 1'b1;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  localparam int IN_DATA_W   = 32;
  localparam int IN_PRIO_W   = 16;
  localparam int FILL_W      = 8;

  typedef struct packed {
    logic enq;
    logic deq;
  } cmd_t;

endpackage

@@ design/spq_cell.sv @@
module spq_cell #(
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  spq_pkg::cmd_t             cmd,
  input  logic [DATA_WIDTH-1:0]     new_data,
  input  logic [PRIORITY_WIDTH-1:0] new_prio,
  input  logic                      left_gt,
  input  logic                      left_valid,
  input  logic [DATA_WIDTH-1:0]     left_data,
  input  logic [PRIORITY_WIDTH-1:0] left_prio,
  input  logic                      right_valid,
  input  logic [DATA_WIDTH-1:0]     right_data,
  input  logic [PRIORITY_WIDTH-1:0] right_prio,
  output logic                      gt,
  output logic                      valid,
  output logic [DATA_WIDTH-1:0]     data,
  output logic [PRIORITY_WIDTH-1:0] prio
);

  logic                      valid_r;
  logic                      valid_nxt;
  logic [DATA_WIDTH-1:0]     data_r;
  logic [DATA_WIDTH-1:0]     data_nxt;
  logic [PRIORITY_WIDTH-1:0] prio_r;
  logic [PRIORITY_WIDTH-1:0] prio_nxt;

  // An empty cell counts as holding a larger key, so the flags along the row stay monotone.
  assign gt = !valid_r || ($signed(prio_r) > $signed(new_prio));

  always_comb begin
    valid_nxt = valid_r;
    data_nxt  = data_r;
    prio_nxt  = prio_r;
    if (cmd.enq && gt) begin
      if (left_gt) begin
        valid_nxt = left_valid;
        data_nxt  = left_data;
        prio_nxt  = left_prio;
      end else begin
        valid_nxt = 1'b1;
        data_nxt  = new_data;
        prio_nxt  = new_prio;
      end
    end else if (cmd.deq) begin
      valid_nxt = right_valid;
      data_nxt  = right_data;
      prio_nxt  = right_prio;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    prio_r <= prio_nxt;
  end

  assign valid = valid_r;
  assign data  = data_r;
  assign prio  = prio_r;

endmodule

@@ design/sorted_priority_queue_unit.sv @@
// Channel  Direction  Handshake            Word
// in_      input      in_valid / in_stall   in_action, in_data, in_priority
// out_     output     out_valid / out_stall out_data, out_priority, out_status, out_fill_count
//
// One word is accepted per cycle while in_stall is low; its result is presented in the next cycle.
// Every cell of the row compares its key with the new priority in the same cycle.
// Reset clears all cell valid flags and the entry count; no clearing pass is needed.
// The input stalls only while a result waits in the output register and out_stall is high.
module sorted_priority_queue_unit #(
  parameter int DEPTH          = 128,
  parameter int DATA_WIDTH     = 32,
  parameter int PRIORITY_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [31:0] in_data,
  input  logic [15:0] in_priority,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_data,
  output logic [15:0] out_priority,
  output logic [1:0]  out_status,
  output logic [7:0]  out_fill_count
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                      valid_w [DEPTH];
  logic [DATA_WIDTH-1:0]     data_w  [DEPTH];
  logic [PRIORITY_WIDTH-1:0] prio_w  [DEPTH];
  logic                      gt_w    [DEPTH];

  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::cmd_t             cmd;
  logic [DATA_WIDTH-1:0]     new_data;
  logic [PRIORITY_WIDTH-1:0] new_prio;
  logic [DATA_WIDTH+31:0]    data_wide;
  logic [DATA_WIDTH+63:0]    in_data_wide;
  logic [PRIORITY_WIDTH+15:0] prio_wide;
  logic [PRIORITY_WIDTH+31:0] in_prio_wide;
  logic [CNT_W+7:0]          cnt_wide;

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic [31:0]               out_data_r;
  logic [31:0]               out_data_nxt;
  logic [15:0]               out_prio_r;
  logic [15:0]               out_prio_nxt;
  logic [1:0]                out_status_r;
  logic [1:0]                out_status_nxt;
  logic [7:0]                out_fill_r;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r == CNT_W'(DEPTH);
  assign empty    = count_r == '0;

  assign in_data_wide = {{(DATA_WIDTH + 32){in_data[31]}}, in_data};
  assign in_prio_wide = {{(PRIORITY_WIDTH + 16){in_priority[15]}}, in_priority};
  assign new_data     = in_data_wide[DATA_WIDTH-1:0];
  assign new_prio     = in_prio_wide[PRIORITY_WIDTH-1:0];

  assign cmd.enq = accept && (in_action == spq_pkg::ACT_ENQUEUE) && !full;
  assign cmd.deq = accept && (in_action == spq_pkg::ACT_DEQUEUE) && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                      l_gt;
      logic                      l_valid;
      logic [DATA_WIDTH-1:0]     l_data;
      logic [PRIORITY_WIDTH-1:0] l_prio;
      logic                      r_valid;
      logic [DATA_WIDTH-1:0]     r_data;
      logic [PRIORITY_WIDTH-1:0] r_prio;

      if (g == 0) begin : g_head
        assign l_gt    = 1'b0;
        assign l_valid = 1'b0;
        assign l_data  = '0;
        assign l_prio  = '0;
      end else begin : g_body
        assign l_gt    = gt_w[g-1];
        assign l_valid = valid_w[g-1];
        assign l_data  = data_w[g-1];
        assign l_prio  = prio_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign r_valid = 1'b0;
        assign r_data  = '0;
        assign r_prio  = '0;
      end else begin : g_inner
        assign r_valid = valid_w[g+1];
        assign r_data  = data_w[g+1];
        assign r_prio  = prio_w[g+1];
      end

      spq_cell #(
        .DATA_WIDTH     (DATA_WIDTH),
        .PRIORITY_WIDTH (PRIORITY_WIDTH)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .new_data    (new_data),
        .new_prio    (new_prio),
        .left_gt     (l_gt),
        .left_valid  (l_valid),
        .left_data   (l_data),
        .left_prio   (l_prio),
        .right_valid (r_valid),
        .right_data  (r_data),
        .right_prio  (r_prio),
        .gt          (gt_w[g]),
        .valid       (valid_w[g]),
        .data        (data_w[g]),
        .prio        (prio_w[g])
      );
    end
  endgenerate

  assign data_wide = {{32{data_w[0][DATA_WIDTH-1]}}, data_w[0]};
  assign prio_wide = {{16{prio_w[0][PRIORITY_WIDTH-1]}}, prio_w[0]};

  always_comb begin
    count_nxt      = count_r;
    out_data_nxt   = '0;
    out_prio_nxt   = '0;
    out_status_nxt = spq_pkg::ST_DONE;
    if (in_action == spq_pkg::ACT_ENQUEUE) begin
      if (full) begin
        out_status_nxt = spq_pkg::ST_OVERFLOW;
      end else begin
        count_nxt = count_r + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        out_status_nxt = spq_pkg::ST_UNDERFLOW;
      end else begin
        count_nxt    = count_r - CNT_W'(1);
        out_data_nxt = data_wide[31:0];
        out_prio_nxt = prio_wide[15:0];
      end
    end
  end

  assign cnt_wide = {8'd0, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r   <= out_data_nxt;
      out_prio_r   <= out_prio_nxt;
      out_status_r <= out_status_nxt;
      out_fill_r   <= cnt_wide[7:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;
  assign out_priority   = out_prio_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_fill_r;

  a_head_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) == !valid_w[0])
    else $error("head cell occupancy disagrees with the entry count");

  a_tail_matches_full: assert property (@(posedge clk) disable iff (!rst_n)
    valid_w[DEPTH-1] == full)
    else $error("last cell occupancy disagrees with the full flag");

  a_overflow_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_action == spq_pkg::ACT_ENQUEUE) && full
    |=> out_status_r == spq_pkg::ST_OVERFLOW && $stable(count_r))
    else $error("enqueue on a full queue not reported as overflow");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

class queue_tracker;
  localparam int ENTRY_LIMIT = 128;

  typedef struct {
    logic [31:0] data;
    logic [15:0] prio;
    logic [1:0]  status;
    logic [7:0]  fill;
  } queue_result_t;

  logic [31:0]   held_data [ENTRY_LIMIT];
  logic [15:0]   held_prio [ENTRY_LIMIT];
  int            held;
  queue_result_t awaited_results[$];
  int            errors;

  function new();
    held   = 0;
    errors = 0;
  endfunction

  function int pending();
    return awaited_results.size();
  endfunction

  // Works out the result of one accepted word and files it for checking.
  function void note_word(logic act, logic [31:0] data, logic [15:0] prio);
    queue_result_t r;
    int i;
    r.data   = '0;
    r.prio   = '0;
    r.status = spq_pkg::ST_DONE;
    if (act == spq_pkg::ACT_ENQUEUE) begin
      if (held >= ENTRY_LIMIT) begin
        r.status = spq_pkg::ST_OVERFLOW;
      end else begin
        i = held;
        while (i > 0 && $signed(held_prio[i-1]) > $signed(prio)) begin
          held_data[i] = held_data[i-1];
          held_prio[i] = held_prio[i-1];
          i--;
        end
        held_data[i] = data;
        held_prio[i] = prio;
        held++;
      end
    end else begin
      if (held == 0) begin
        r.status = spq_pkg::ST_UNDERFLOW;
      end else begin
        r.data = held_data[0];
        r.prio = held_prio[0];
        for (i = 1; i < held; i++) begin
          held_data[i-1] = held_data[i];
          held_prio[i-1] = held_prio[i];
        end
        held--;
      end
    end
    r.fill = 8'(held);
    awaited_results.push_back(r);
  endfunction

  function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      errors++;
    end
  endfunction

  function void check_result(logic [31:0] data, logic [15:0] prio, logic [1:0] status,
                             logic [7:0] fill);
    queue_result_t r;
    if (awaited_results.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual data %h prio %h status %h fill %h",
               $time, data, prio, status, fill);
      errors++;
    end else begin
      r = awaited_results.pop_front();
      compare_field("out_data", r.data, data);
      compare_field("out_priority", 32'(r.prio), 32'(prio));
      compare_field("out_status", 32'(r.status), 32'(status));
      compare_field("out_fill_count", 32'(r.fill), 32'(fill));
    end
  endfunction
endclass

module testbench;
  localparam int DEPTH       = 128;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_action;
  logic [31:0] in_data;
  logic [15:0] in_priority;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_data;
  logic [15:0] out_priority;
  logic [1:0]  out_status;
  logic [7:0]  out_fill_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;

  queue_tracker tracker = new();

  sorted_priority_queue_unit #(
    .DEPTH         (DEPTH),
    .DATA_WIDTH    (32),
    .PRIORITY_WIDTH(16)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_action     (in_action),
    .in_data       (in_data),
    .in_priority   (in_priority),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .out_priority  (out_priority),
    .out_status    (out_status),
    .out_fill_count(out_fill_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.check_result(out_data, out_priority, out_status, out_fill_count);
      end
      if (in_valid && !in_stall) begin
        tracker.note_word(in_action, in_data, in_priority);
      end
    end
  end

  // The long hold-off is counted here so that the sender keeps offering words meanwhile.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic offer_word(input logic act, input logic [31:0] data, input logic [15:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_data     <= data;
    in_priority <= prio;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic random_words(input int count, input int enq_pct);
    logic        act;
    logic [15:0] prio;
    for (int k = 0; k < count; k++) begin
      act = ($urandom_range(99) < enq_pct) ? spq_pkg::ACT_ENQUEUE : spq_pkg::ACT_DEQUEUE;
      if ($urandom_range(1) == 1) begin
        prio = 16'($urandom_range(6)) - 16'd3;
      end else begin
        prio = 16'($urandom);
      end
      offer_word(act, $urandom, prio);
    end
  endtask

  task automatic mixed_words(input int blocks);
    int bias [4] = '{20, 50, 70, 90};
    for (int b = 0; b < blocks; b++) begin
      random_words(50, bias[$urandom_range(3)]);
    end
  endtask

  task automatic fill_and_drain();
    random_words(DEPTH + 5, 100);
    random_words(DEPTH + 5, 0);
  endtask

  // Pending words are counted at the falling edge, once the last accepted word has been noted.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (tracker.pending() != 0);
    @(posedge clk);
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_action   <= spq_pkg::ACT_ENQUEUE;
    in_data     <= '0;
    in_priority <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    offer_word(spq_pkg::ACT_DEQUEUE, 32'hFFFF_FFFF, 16'h7FFF);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h7FFF_FFFF, 16'h7FFF);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h8000_0000, 16'h8000);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h0000_0000, 16'h0000);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'hFFFF_FFFF, 16'hFFFF);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h1234_5678, 16'h0000);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h0BAD_F00D, 16'h0000);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h0000_0001, 16'h8000);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h0000_0002, 16'h7FFF);
    offer_word(spq_pkg::ACT_DEQUEUE, 32'h5555_5555, 16'h5555);
    offer_word(spq_pkg::ACT_ENQUEUE, 32'h0000_0003, 16'h0001);
    for (int k = 0; k < 9; k++) begin
      offer_word(spq_pkg::ACT_DEQUEUE, (k % 2 == 1) ? 32'hAAAA_AAAA : 32'h5555_5555,
                 (k % 2 == 1) ? 16'hAAAA : 16'h5555);
    end
    offer_word(spq_pkg::ACT_DEQUEUE, 32'h0000_0000, 16'h0000);
    wait_for_results();

    hold_request = 1'b1;
    random_words(60, 90);
    wait_for_results();
    fill_and_drain();
    mixed_words(3);
    wait_for_results();

    send_idle_pct = 74;
    mixed_words(6);
    wait_for_results();

    send_idle_pct = 0;
    stall_pct     = 74;
    fill_and_drain();
    mixed_words(2);
    wait_for_results();

    send_idle_pct = 29;
    stall_pct     = 29;
    mixed_words(6);
    wait_for_results();

    repeat (10) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
